// ===== src/tcce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
`default_nettype none

package tcce_pkg;

    localparam logic [7:0] CH_RUBOUT    = 8'h7F;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] TAB_STEP = 8'd8;

    localparam logic [7:0] COL_COUNT_RST = 8'd100;
    localparam logic [7:0] ROW_COUNT_RST = 8'd37;

    localparam logic REG_COL_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] glyph;
        logic       last;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: cursor tracking and command output queue.
`default_nettype none

// Each accepted character word is latched in an input register; once the output queue has room it
// updates the cursor and loads zero, one or two commands (draw, scroll, or draw then scroll) into a
// two-entry output queue. A character is taken every cycle while the consumer takes every
// command; a character that yields two commands holds off the next character, which is
// processed once the queue will be empty. The first command of a character passes through
// the input register and then the output queue before it is presented. Configuration writes
// are always ready and take effect at once.
module text_console_cursor_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_command_kind,
    output logic [7:0]      o_cell_column,
    output logic [7:0]      o_cell_row,
    output logic [7:0]      o_glyph_code,
    output logic            o_last_of_run,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_col_count;
    logic [7:0] r_row_count;
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic       r_in_v;
    logic [7:0] r_in_char;
    tcce_pkg::t_cmd r_q [2];
    logic       r_head;
    logic [1:0] r_cnt;

    logic       pop;
    logic       fire;
    logic [7:0] n_col;
    logic [7:0] n_row;
    logic [1:0] n_cnt;
    tcce_pkg::t_cmd cmd0;
    tcce_pkg::t_cmd cmd1;

    logic [8:0] row_inc;
    logic       wrap_scroll;
    logic [7:0] wrap_row;
    logic       do_wrap;
    logic [8:0] col_inc;
    logic [9:0] tab_fwd;
    logic [8:0] tab_next;
    logic [9:0] tab_chk;

    assign o_cfg_ready = 1'b1;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && !i_stall;
    assign fire = r_in_v && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign o_stall = r_in_v && !fire;

    assign o_command_kind = r_q[r_head].kind;
    assign o_cell_column = r_q[r_head].column;
    assign o_cell_row = r_q[r_head].row;
    assign o_glyph_code = r_q[r_head].glyph;
    assign o_last_of_run = r_q[r_head].last;

    assign row_inc = {1'b0, r_row} + 9'd1;
    assign wrap_scroll = row_inc >= {1'b0, r_row_count};
    assign wrap_row = (r_row_count != 8'd0) ? (r_row_count - 8'd1) : 8'd0;
    assign col_inc = {1'b0, r_col} + 9'd1;
    assign tab_fwd = {2'b00, r_col} + {2'b00, tcce_pkg::TAB_STEP};
    assign tab_next = {1'b0, r_col | 8'h07} + 9'd1;
    assign tab_chk = {1'b0, tab_next} + {2'b00, tcce_pkg::TAB_STEP};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cnt = 2'd0;
        do_wrap = 1'b0;
        cmd0 = '{kind: tcce_pkg::CMD_DRAW, column: r_col, row: r_row, glyph: r_in_char,
                 last: 1'b1};
        cmd1 = '{kind: tcce_pkg::CMD_SCROLL, column: 8'd0, row: 8'd0, glyph: 8'd0,
                 last: 1'b1};
        unique case (r_in_char)
            tcce_pkg::CH_RUBOUT, tcce_pkg::CH_BACKSPACE: begin
                if (r_col == 8'd0) begin
                    if (r_row != 8'd0) begin
                        n_row = r_row - 8'd1;
                        n_col = (r_col_count != 8'd0) ? (r_col_count - 8'd1) : 8'd0;
                    end
                end else begin
                    n_col = r_col - 8'd1;
                end
                cmd0.column = n_col;
                cmd0.row = n_row;
                cmd0.glyph = (r_in_char == tcce_pkg::CH_RUBOUT) ? tcce_pkg::CH_SPACE
                                                                : tcce_pkg::CH_BACKSPACE;
                n_cnt = 2'd1;
            end
            tcce_pkg::CH_TAB: begin
                if (r_col[2:0] == 3'd0) begin
                    do_wrap = (tab_fwd + {2'b00, tcce_pkg::TAB_STEP}) >= {2'b00, r_col_count};
                    n_col = tab_fwd[7:0];
                end else begin
                    do_wrap = tab_chk > {2'b00, r_col_count};
                    n_col = tab_next[7:0];
                end
                cmd0 = cmd1;
                n_cnt = (do_wrap && wrap_scroll) ? 2'd1 : 2'd0;
            end
            tcce_pkg::CH_FORMFEED: begin
                n_col = 8'd0;
                n_row = 8'd0;
            end
            tcce_pkg::CH_RETURN: begin
                n_col = 8'd0;
            end
            tcce_pkg::CH_NEWLINE: begin
                do_wrap = 1'b1;
                cmd0 = cmd1;
                n_cnt = wrap_scroll ? 2'd1 : 2'd0;
            end
            default: begin
                do_wrap = col_inc >= {1'b0, r_col_count};
                n_col = col_inc[7:0];
                cmd0.last = !(do_wrap && wrap_scroll);
                n_cnt = (do_wrap && wrap_scroll) ? 2'd2 : 2'd1;
            end
        endcase
        if (do_wrap) begin
            n_col = 8'd0;
            n_row = wrap_scroll ? wrap_row : row_inc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= tcce_pkg::COL_COUNT_RST;
            r_row_count <= tcce_pkg::ROW_COUNT_RST;
            r_col <= 8'd0;
            r_row <= 8'd0;
            r_in_v <= 1'b0;
            r_head <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tcce_pkg::REG_COL_COUNT) begin
                    r_col_count <= i_cfg_data;
                end else begin
                    r_row_count <= i_cfg_data;
                end
            end
            if (i_valid && !o_stall) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_col <= n_col;
                r_row <= n_row;
                r_head <= 1'b0;
                r_cnt <= n_cnt;
            end else if (pop) begin
                r_head <= ~r_head;
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_char_code;
        end
        if (fire) begin
            r_q[0] <= cmd0;
            r_q[1] <= cmd1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop))
        else $error("character processed without queue room");

    a_scroll_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_command_kind == tcce_pkg::CMD_SCROLL) |->
            (o_cell_column == 8'd0) && (o_cell_row == 8'd0) && (o_glyph_code == 8'd0)
            && o_last_of_run)
        else $error("scroll word carries nonzero fields or is not last");

    a_draw_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> (r_cnt == 2'd2)
            && (r_q[~r_head].kind == tcce_pkg::CMD_SCROLL))
        else $error("draw word not last but no scroll word queued behind it");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == 2'd0) && !r_in_v)
        else $error("queue not empty after reset");

endmodule

`default_nettype wire

// ===== tb/cursor_command_checker.sv =====
// Cursor command checker: predicts and compares the commands of the text console cursor engine.
`timescale 1ns / 100ps

module cursor_command_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_char_valid,
    input  wire logic       i_char_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_cmd_valid,
    input  wire logic       i_cmd_stall,
    input  wire logic       i_cmd_kind,
    input  wire logic [7:0] i_cmd_column,
    input  wire logic [7:0] i_cmd_row,
    input  wire logic [7:0] i_cmd_glyph,
    input  wire logic       i_cmd_last,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_cmd_count,
    output int              o_scroll_count
);

    localparam int unsigned TAB_COLS = 32'(tcce_pkg::TAB_STEP);

    logic [7:0]  column_count;
    logic [7:0]  row_count;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    int unsigned work_col;
    int unsigned work_row;
    bit          scrolled;
    tcce_pkg::t_cmd expected_cmds[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_cmd_count = 0;
        o_scroll_count = 0;
    end

    task line_feed;
        work_row = work_row + 1;
        work_col = 0;
        if (work_row >= 32'(row_count)) begin
            work_row = (row_count != 8'd0) ? 32'(row_count) - 1 : 0;
            scrolled = 1'b1;
        end
    endtask

    task push_cmd(input logic kind, input logic [7:0] column, input logic [7:0] row,
                  input logic [7:0] glyph, input logic last);
        tcce_pkg::t_cmd cmd;
        cmd.kind = kind;
        cmd.column = column;
        cmd.row = row;
        cmd.glyph = glyph;
        cmd.last = last;
        expected_cmds.push_back(cmd);
    endtask

    task predict_commands(input logic [7:0] ch);
        int unsigned draw_col;
        int unsigned draw_row;
        int unsigned ncol;
        work_col = 32'(cursor_col);
        work_row = 32'(cursor_row);
        ncol = 32'(column_count);
        scrolled = 1'b0;
        if (ch == tcce_pkg::CH_RUBOUT || ch == tcce_pkg::CH_BACKSPACE) begin
            if (work_col == 0) begin
                if (work_row != 0) begin
                    work_row = work_row - 1;
                    work_col = (ncol != 0) ? ncol - 1 : 0;
                end
            end else begin
                work_col = work_col - 1;
            end
            push_cmd(tcce_pkg::CMD_DRAW, work_col[7:0], work_row[7:0],
                     (ch == tcce_pkg::CH_RUBOUT) ? tcce_pkg::CH_SPACE
                                                 : tcce_pkg::CH_BACKSPACE, 1'b1);
        end else if (ch == tcce_pkg::CH_TAB) begin
            if (work_col % TAB_COLS == 0) begin
                work_col = work_col + TAB_COLS;
                if (work_col + TAB_COLS >= ncol) line_feed();
            end
            while (work_col % TAB_COLS != 0) begin
                work_col = work_col + 1;
                if (work_col + TAB_COLS > ncol) line_feed();
            end
        end else if (ch == tcce_pkg::CH_FORMFEED) begin
            work_col = 0;
            work_row = 0;
        end else if (ch == tcce_pkg::CH_RETURN) begin
            work_col = 0;
        end else if (ch == tcce_pkg::CH_NEWLINE) begin
            line_feed();
        end else begin
            draw_col = work_col;
            draw_row = work_row;
            work_col = work_col + 1;
            if (work_col >= ncol) line_feed();
            push_cmd(tcce_pkg::CMD_DRAW, draw_col[7:0], draw_row[7:0], ch, !scrolled);
        end
        if (scrolled) push_cmd(tcce_pkg::CMD_SCROLL, 8'd0, 8'd0, 8'd0, 1'b1);
        cursor_col = work_col[7:0];
        cursor_row = work_row[7:0];
    endtask

    always @(posedge i_clk) begin : watch
        tcce_pkg::t_cmd want;
        if (!i_rst_n) begin
            column_count = tcce_pkg::COL_COUNT_RST;
            row_count = tcce_pkg::ROW_COUNT_RST;
            cursor_col = 8'd0;
            cursor_row = 8'd0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == tcce_pkg::REG_COL_COUNT) begin
                    column_count = i_cfg_data;
                end else begin
                    row_count = i_cfg_data;
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                o_cmd_count = o_cmd_count + 1;
                if (i_cmd_kind === tcce_pkg::CMD_SCROLL) o_scroll_count = o_scroll_count + 1;
                if (expected_cmds.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected command kind %0d col %0d row %0d %s",
                                 $realtime, i_cmd_kind, i_cmd_column, i_cmd_row,
                                 $sformatf("glyph %02h last %0d", i_cmd_glyph, i_cmd_last));
                    end
                end else begin
                    want = expected_cmds.pop_front();
                    if (want.kind !== i_cmd_kind || want.column !== i_cmd_column ||
                        want.row !== i_cmd_row || want.glyph !== i_cmd_glyph ||
                        want.last !== i_cmd_last) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: command mismatch: expected kind %0d col %0d %s",
                                     $realtime, want.kind, want.column,
                                     $sformatf("row %0d glyph %02h last %0d",
                                               want.row, want.glyph, want.last));
                            $display("%0t:                   got      kind %0d col %0d %s",
                                     $realtime, i_cmd_kind, i_cmd_column,
                                     $sformatf("row %0d glyph %02h last %0d",
                                               i_cmd_row, i_cmd_glyph, i_cmd_last));
                        end
                    end
                end
            end
            if (i_char_valid && !i_char_stall) predict_commands(i_char_code);
        end
        o_pending = expected_cmds.size();
    end

endmodule

// ===== tb/text_console_cursor_engine_tb.sv =====
// Testbench top of the text console cursor engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module text_console_cursor_engine_tb;

    localparam int PHASE_ITEMS = 205;
    localparam int NUM_PHASES  = 9;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_code;
    logic       o_valid;
    logic       i_stall;
    logic       o_command_kind;
    logic [7:0] o_cell_column;
    logic [7:0] o_cell_row;
    logic [7:0] o_glyph_code;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    int fail_count;
    int pending;
    int cmd_count;
    int scroll_count;
    int chars_sent = 0;
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    text_console_cursor_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_kind (o_command_kind),
        .o_cell_column  (o_cell_column),
        .o_cell_row     (o_cell_row),
        .o_glyph_code   (o_glyph_code),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    cursor_command_checker cmd_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (i_valid),
        .i_char_stall   (o_stall),
        .i_char_code    (i_char_code),
        .i_cmd_valid    (o_valid),
        .i_cmd_stall    (i_stall),
        .i_cmd_kind     (o_command_kind),
        .i_cmd_column   (o_cell_column),
        .i_cmd_row      (o_cell_row),
        .i_cmd_glyph    (o_glyph_code),
        .i_cmd_last     (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cmd_count    (cmd_count),
        .o_scroll_count (scroll_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 8'($urandom_range(tcce_pkg::CH_SPACE, tcce_pkg::CH_RUBOUT - 1));
        if (pick < 55) return tcce_pkg::CH_NEWLINE;
        if (pick < 63) return tcce_pkg::CH_TAB;
        if (pick < 68) return tcce_pkg::CH_RETURN;
        if (pick < 70) return tcce_pkg::CH_FORMFEED;
        if (pick < 77) return tcce_pkg::CH_BACKSPACE;
        if (pick < 83) return tcce_pkg::CH_RUBOUT;
        return 8'($urandom_range(0, 255));
    endfunction

    // The valid stays high after acceptance; the next word or a gap replaces it.
    task send_char(input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_stall);
        chars_sent = chars_sent + 1;
    endtask

    task drain_commands(input int settle);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task write_reg(input logic index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int run_left;
        run_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
                i_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left = run_left - 1;
            end else if (idle_on && $urandom_range(0, 99) < 30) begin
                i_stall <= 1'b1;
                run_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                        : $urandom_range(7, 39);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Run timed out.");
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] cols;
        logic [7:0] rows;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_char_code = 8'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tcce_pkg::REG_COL_COUNT;
        i_cfg_data = 8'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opening words at the reset geometry: step back at home, edge codes, tabs and wraps.
        send_char(tcce_pkg::CH_BACKSPACE);
        send_char(tcce_pkg::CH_RUBOUT);
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(tcce_pkg::CH_RUBOUT);
        send_char(tcce_pkg::CH_TAB);
        send_char(tcce_pkg::CH_TAB);
        send_char(tcce_pkg::CH_RETURN);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_BACKSPACE);
        send_char(8'h5A);
        send_char(tcce_pkg::CH_FORMFEED);
        send_char(tcce_pkg::CH_NEWLINE);

        // A single-row, narrow screen makes every line feed scroll.
        drain_commands(SETTLE);
        write_reg(tcce_pkg::REG_COL_COUNT, 8'd16);
        write_reg(tcce_pkg::REG_ROW_COUNT, 8'd1);
        send_char(tcce_pkg::CH_NEWLINE);
        send_char(tcce_pkg::CH_TAB);
        send_char(8'h78);
        send_char(tcce_pkg::CH_TAB);
        send_char(tcce_pkg::CH_TAB);
        send_char(tcce_pkg::CH_BACKSPACE);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cols = 8'd16;  rows = 8'd1;   end
                1: begin cols = 8'd255; rows = 8'd255; end
                2: begin cols = 8'd16;  rows = 8'd255; end
                3: begin cols = 8'd255; rows = 8'd1;   end
                4: begin cols = 8'd40;  rows = 8'd3;   end
                5: begin cols = 8'd0;   rows = 8'd2;   end
                6: begin cols = 8'd7;   rows = 8'd0;   end
                default: begin
                    cols = 8'($urandom_range(16, 255));
                    rows = 8'($urandom_range(1, 255));
                end
            endcase
            drain_commands(SETTLE);
            write_reg(tcce_pkg::REG_COL_COUNT, cols);
            write_reg(tcce_pkg::REG_ROW_COUNT, rows);
            idle_on = (p != 2);
            if (p == 4) begin
                idle_on = 1'b0;
                long_hold = 1'b1;
                repeat (24) send_char(random_char());
                idle_on = 1'b1;
            end
            repeat (PHASE_ITEMS) send_char(random_char());
        end

        drain_commands(SETTLE);
        $display("Sent %0d characters over %0d screen geometries, including out-of-range ones.",
                 chars_sent, NUM_PHASES + 2);
        $display("Checked %0d commands (%0d scrolls); %0d mismatches, %0d commands never arrived.",
                 cmd_count, scroll_count, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
